/* rtl/satlm_pkg.sv */
// ---------------------------------------------------------------------------
// satlm_pkg: shared types and constants of the acknowledgement low mark tracker
// Holds the transaction payload types, the table entry type and the
// default sizes that the top level hands down to its memories.
// ---------------------------------------------------------------------------
package satlm_pkg;

  localparam int unsigned SeqW         = 64;
  localparam int unsigned NodeW        = 4;
  localparam int unsigned TrackDepthDef = 8;
  localparam int unsigned NodeCountDef  = 16;

  typedef struct packed {
    logic [NodeW-1:0] node_index;
    logic [SeqW-1:0]  reported_seq;
  } in_t;

  typedef struct packed {
    logic [SeqW-1:0] low_mark;
    logic            status;
  } out_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [SeqW-1:0]  seq;
  } entry_t;

endpackage

/* rtl/satlm_cmp.sv */
// ---------------------------------------------------------------------------
// satlm_cmp: shared sequence comparator
// One 64-bit unsigned magnitude compare, reused by the steps of the
// sequencer that compare: against the node's last value and against table entries.
// ---------------------------------------------------------------------------
module satlm_cmp (
  input  logic [satlm_pkg::SeqW-1:0] a_i,
  input  logic [satlm_pkg::SeqW-1:0] b_i,
  output logic                       gt_o,
  output logic                       eq_o
);
  import satlm_pkg::*;

  assign gt_o = (a_i > b_i);
  assign eq_o = (a_i == b_i);

endmodule

/* rtl/satlm_tbl.sv */
// ---------------------------------------------------------------------------
// satlm_tbl: sorted entry memory
// One write port and one read port with registered read data. Entries are
// undefined until written; the sequencer only reads below the fill count.
// ---------------------------------------------------------------------------
module satlm_tbl #(
  parameter int unsigned DEPTH = satlm_pkg::TrackDepthDef,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  satlm_pkg::entry_t wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output satlm_pkg::entry_t rdata_o
);
  import satlm_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/satlm_last.sv */
// ---------------------------------------------------------------------------
// satlm_last: per-node last recorded sequence
// Memory with registered read data and one valid bit per node; a node that
// was never written reads as zero, which matches the reset state.
// ---------------------------------------------------------------------------
module satlm_last #(
  parameter int unsigned COUNT = satlm_pkg::NodeCountDef,
  localparam int unsigned AW   = $clog2(COUNT)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [satlm_pkg::SeqW-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [satlm_pkg::SeqW-1:0] rdata_o
);
  import satlm_pkg::*;

  logic [SeqW-1:0]  mem_q [COUNT];
  logic [COUNT-1:0] vld_q;
  logic [SeqW-1:0]  rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

/* rtl/sorted_ack_tracker_low_mark.sv */
// ---------------------------------------------------------------------------
// sorted_ack_tracker_low_mark: acknowledgement low-water mark tracker
// Sequencing: an update's result strobe waits on the entry memory walk at one
//   entry per cycle and, for an insert, on the shift pass; a stale report
//   holds busy for one cycle.
// Throughput: one transaction at a time; busy stays high through the result.
// Reset: asynchronous, active low; the table empties and every node's last
//   sequence reads as zero. The receiver cannot stall the result strobe.
// ---------------------------------------------------------------------------
module sorted_ack_tracker_low_mark #(
  parameter int unsigned TRACK_DEPTH = satlm_pkg::TrackDepthDef,
  parameter int unsigned NODE_COUNT  = satlm_pkg::NodeCountDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  satlm_pkg::in_t  in_i,
  output logic            result_valid_o,
  output satlm_pkg::out_t result_o
);
  import satlm_pkg::*;

  localparam int unsigned TW = $clog2(TRACK_DEPTH);
  localparam int unsigned CW = $clog2(TRACK_DEPTH + 1);
  localparam int unsigned NW = $clog2(NODE_COUNT);

  // Sequencer states. The table memory is read one entry per cycle, so every
  // state that consumes an entry had its address issued by the state before.
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_LAST  = 8'b0000_0010,
    ST_SCAN  = 8'b0000_0100,
    ST_BUB   = 8'b0000_1000,
    ST_SHIFT = 8'b0001_0000,
    ST_PUT   = 8'b0010_0000,
    ST_RD0   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [NodeW-1:0]  node_q, node_d;
  logic [SeqW-1:0]   seq_q, seq_d;
  logic [CW-1:0]     cur_q, cur_d;    // table cursor
  logic [CW-1:0]     pos_q, pos_d;    // final slot of the reported pair
  logic [CW-1:0]     cnt_q, cnt_d;    // number of valid table entries
  logic              full_q, full_d;  // new node dropped, table full
  logic              ins_q, ins_d;    // a new entry is being inserted

  // Table memory port.
  logic              tbl_we;
  logic [TW-1:0]     tbl_waddr;
  entry_t            tbl_wdata;
  logic [TW-1:0]     tbl_raddr;
  entry_t            tbl_rdata;

  // Per-node memory port.
  logic              last_we;
  logic [NW-1:0]     last_addr;
  logic [SeqW-1:0]   last_rdata;

  // Shared comparator: the reported sequence against either the node's last
  // value or the table entry that was just read.
  logic [SeqW-1:0]   cmp_b;
  logic              cmp_gt;
  logic              cmp_eq;

  logic [CW-1:0]     cur_inc;
  logic [CW-1:0]     cur_dec;
  logic [CW-1:0]     cnt_dec;
  logic [CW-1:0]     pos_next;
  logic              node_ok;

  assign cur_inc  = cur_q + CW'(1);
  assign cur_dec  = cur_q - CW'(1);
  assign cnt_dec  = cnt_q - CW'(1);
  assign pos_next = cmp_gt ? cur_inc : pos_q;
  assign node_ok  = ({28'd0, node_q} < 32'(NODE_COUNT));

  assign cmp_b = (state_q == ST_LAST) ? last_rdata : tbl_rdata.seq;

  satlm_cmp u_cmp (
    .a_i  (seq_q),
    .b_i  (cmp_b),
    .gt_o (cmp_gt),
    .eq_o (cmp_eq)
  );

  satlm_tbl #(
    .DEPTH (TRACK_DEPTH)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // The node memory is read at acceptance and written in the cycle after, so a
  // single address serves both.
  assign last_addr = (state_q == ST_IDLE) ? NW'(32'(in_i.node_index)) : NW'(32'(node_q));

  satlm_last #(
    .COUNT (NODE_COUNT)
  ) u_last (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (last_we),
    .waddr_i (last_addr),
    .wdata_i (seq_q),
    .raddr_i (last_addr),
    .rdata_o (last_rdata)
  );

  always_comb begin
    state_d   = state_q;
    node_d    = node_q;
    seq_d     = seq_q;
    cur_d     = cur_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    full_d    = full_q;
    ins_d     = ins_q;
    tbl_we    = 1'b0;
    tbl_waddr = '0;
    tbl_wdata = '{node: node_q, seq: seq_q};
    tbl_raddr = '0;
    last_we   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          node_d  = in_i.node_index;
          seq_d   = in_i.reported_seq;
          state_d = ST_LAST;
        end
      end

      // Drop stale or out-of-range reports; else record it, then scan or put.
      ST_LAST: begin
        if (!node_ok || !cmp_gt) begin
          state_d = ST_IDLE;
        end else begin
          last_we = 1'b1;
          full_d  = 1'b0;
          ins_d   = 1'b0;
          cur_d   = '0;
          pos_d   = '0;
          if (cnt_q == '0) begin
            ins_d   = 1'b1;
            state_d = ST_PUT;
          end else begin
            tbl_raddr = '0;
            state_d   = ST_SCAN;
          end
        end
      end

      // Walk the table looking for the node, counting smaller entries on the
      // way to find the insertion slot of a new node.
      ST_SCAN: begin
        if (tbl_rdata.node == node_q) begin
          if (cmp_eq) begin
            state_d = ST_IDLE;
          end else if (cur_inc < cnt_q) begin
            tbl_raddr = cur_inc[TW-1:0];
            cur_d     = cur_inc;
            state_d   = ST_BUB;
          end else begin
            pos_d   = cur_q;
            state_d = ST_PUT;
          end
        end else begin
          pos_d = pos_next;
          if (cur_inc < cnt_q) begin
            tbl_raddr = cur_inc[TW-1:0];
            cur_d     = cur_inc;
          end else if (cnt_q == CW'(TRACK_DEPTH)) begin
            full_d  = 1'b1;
            state_d = ST_RD0;
          end else begin
            ins_d = 1'b1;
            cur_d = cnt_q;
            if (cnt_q > pos_next) begin
              tbl_raddr = cnt_dec[TW-1:0];
              state_d   = ST_SHIFT;
            end else begin
              state_d = ST_PUT;
            end
          end
        end
      end

      // The raised entry moves right past every smaller successor.
      ST_BUB: begin
        if (cmp_gt) begin
          tbl_we    = 1'b1;
          tbl_waddr = cur_dec[TW-1:0];
          tbl_wdata = tbl_rdata;
          if (cur_inc < cnt_q) begin
            tbl_raddr = cur_inc[TW-1:0];
            cur_d     = cur_inc;
          end else begin
            pos_d   = cur_q;
            state_d = ST_PUT;
          end
        end else begin
          pos_d   = cur_dec;
          state_d = ST_PUT;
        end
      end

      // Open a slot for a new node, moving entries up from the end.
      ST_SHIFT: begin
        tbl_we    = 1'b1;
        tbl_waddr = cur_q[TW-1:0];
        tbl_wdata = tbl_rdata;
        cur_d     = cur_dec;
        if (cur_dec > pos_q) begin
          tbl_raddr = cur_dec[TW-1:0] - TW'(1);
          state_d   = ST_SHIFT;
        end else begin
          state_d = ST_PUT;
        end
      end

      ST_PUT: begin
        tbl_we    = 1'b1;
        tbl_waddr = pos_q[TW-1:0];
        if (ins_q) begin
          cnt_d = cnt_q + CW'(1);
        end
        state_d = ST_RD0;
      end

      // The low mark is always the first entry.
      ST_RD0: begin
        tbl_raddr = '0;
        state_d   = ST_OUT;
      end

      ST_OUT: begin
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      node_q  <= '0;
      seq_q   <= '0;
      cur_q   <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      full_q  <= 1'b0;
      ins_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      node_q  <= node_d;
      seq_q   <= seq_d;
      cur_q   <= cur_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      full_q  <= full_d;
      ins_q   <= ins_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_OUT);
  assign result_o       = '{low_mark: tbl_rdata.seq, status: full_q};

endmodule
